@@ rtl/sss_pkg.sv @@
package sss_pkg;

  // fixed register and field widths
  localparam int SEP_REG_W   = 64;
  localparam int LEN_REG_W   = 4;
  localparam int SPLIT_REG_W = 17;
  localparam int CUT_W       = SPLIT_REG_W - 1;
  localparam int FIELD_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPLITS = 2'd2;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [FIELD_W-1:0] field_start;
    logic [FIELD_W-1:0] field_length;
    logic               final_field;
    logic               length_overflow;
  } result_t;

  // per-cycle control broadcast to every window cell
  typedef struct packed {
    logic shift;  // a byte enters the window
    logic clear;  // cut or end of string: no byte is fresh any more
  } cell_ctl_t;

endpackage

@@ rtl/sss_if.sv @@
interface sss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_string;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_string, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input end_of_string, output ready);
endinterface

interface sss_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] field_start;
  logic [15:0] field_length;
  logic        final_field;
  logic        length_overflow;

  modport source (output valid, output field_start, output field_length,
                  output final_field, output length_overflow, input ready);
  modport sink (input valid, input field_start, input field_length,
                input final_field, input length_overflow, output ready);
endinterface

@@ rtl/sss_cell.sv @@
module sss_cell #(
  parameter int INDEX         = 0,
  parameter int MAX_SEP_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sss_pkg::cell_ctl_t               ctl,
  input  logic [sss_pkg::LEN_REG_W-1:0]    eff_len,
  input  logic [sss_pkg::SEP_REG_W-1:0]    sep_bytes,
  input  logic [sss_pkg::BYTE_W-1:0]       byte_in,
  input  logic                             fresh_in,
  input  logic                             match_in,
  output logic [sss_pkg::BYTE_W-1:0]       byte_out,
  output logic                             fresh_out,
  output logic                             match_out
);
  import sss_pkg::*;

  logic [BYTE_W-1:0] window_byte;
  logic              fresh;
  logic [BYTE_W-1:0] sep_sel;
  logic              active;
  logic              hit;

  // this cell holds window byte INDEX, compared against separator byte len-1-INDEX
  always_comb begin
    sep_sel = '0;
    for (int k = 0; k < MAX_SEP_BYTES; k++) begin
      if (k + INDEX + 1 == int'(eff_len)) begin
        sep_sel = sep_bytes[BYTE_W*k +: BYTE_W];
      end
    end
  end

  assign active = LEN_REG_W'(INDEX) < eff_len;

  // compare on the byte this cell takes next
  assign hit       = !active || (fresh_in && (byte_in == sep_sel));
  assign match_out = match_in && hit;

  // window byte shifts along with each new byte
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      window_byte <= byte_in;
    end
  end

  // fresh marks bytes that arrived after the last cut or end of string
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b0;
    end else if (ctl.clear) begin
      fresh <= 1'b0;
    end else if (ctl.shift) begin
      fresh <= fresh_in;
    end
  end

  assign byte_out  = window_byte;
  assign fresh_out = fresh;

endmodule

@@ rtl/sss_ctrl.sv @@
module sss_ctrl #(
  parameter int POS_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              byte_present,
  input  logic                              end_of_string,
  input  logic                              match,
  input  logic [sss_pkg::LEN_REG_W-1:0]     eff_len,
  input  logic [sss_pkg::SPLIT_REG_W-1:0]   max_splits,
  output sss_pkg::cell_ctl_t                ctl,
  output sss_pkg::result_t                  res0,
  output sss_pkg::result_t                  res1,
  output logic [1:0]                        res_num
);
  import sss_pkg::*;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  logic [POS_WIDTH-1:0] position;
  logic [POS_WIDTH-1:0] field_start;
  logic [CUT_W-1:0]     cuts_done;
  logic                 overflow_seen;

  logic                 take_byte;
  logic                 finish;
  logic                 may_cut;
  logic                 cut;
  logic                 pos_sat;
  logic [POS_WIDTH-1:0] pos_byte;
  logic [POS_WIDTH-1:0] pos_after;
  logic                 ovf_after;
  logic [POS_WIDTH-1:0] len_ext;
  logic [POS_WIDTH-1:0] cut_end;
  logic [POS_WIDTH-1:0] cut_len;
  logic [POS_WIDTH-1:0] start_after;
  logic [POS_WIDTH-1:0] fin_len;
  result_t              cut_res;
  result_t              fin_res;

  assign take_byte = accept && byte_present;
  assign finish    = accept && end_of_string;

  // negative limit means unlimited
  assign may_cut = max_splits[SPLIT_REG_W-1] || (cuts_done < max_splits[CUT_W-1:0]);
  assign cut     = take_byte && match && may_cut;

  // position update with saturation
  assign pos_sat   = position == POS_MAX;
  assign pos_byte  = pos_sat ? POS_MAX : position + POS_WIDTH'(1);
  assign pos_after = take_byte ? pos_byte : position;
  assign ovf_after = overflow_seen || (take_byte && pos_sat);

  // field ended by the cut: from field_start up to the separator
  assign len_ext = POS_WIDTH'(eff_len);
  assign cut_end = (pos_byte >= len_ext) ? pos_byte - len_ext : '0;
  assign cut_len = (cut_end >= field_start) ? cut_end - field_start : '0;

  assign start_after = cut ? pos_byte : field_start;
  assign fin_len     = (pos_after >= start_after) ? pos_after - start_after : '0;

  always_comb begin
    cut_res.field_start     = FIELD_W'(field_start);
    cut_res.field_length    = FIELD_W'(cut_len);
    cut_res.final_field     = 1'b0;
    cut_res.length_overflow = ovf_after;
    fin_res.field_start     = FIELD_W'(start_after);
    fin_res.field_length    = FIELD_W'(fin_len);
    fin_res.final_field     = 1'b1;
    fin_res.length_overflow = ovf_after;
  end

  assign res0    = cut ? cut_res : fin_res;
  assign res1    = fin_res;
  assign res_num = 2'(cut) + 2'(finish);

  assign ctl.shift = take_byte;
  assign ctl.clear = cut || finish;

  // per-string state; end of string returns it to reset
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      position      <= '0;
      field_start   <= '0;
      cuts_done     <= '0;
      overflow_seen <= 1'b0;
    end else if (take_byte) begin
      position      <= pos_byte;
      field_start   <= start_after;
      overflow_seen <= ovf_after;
      if (cut && (cuts_done != '1)) begin
        cuts_done <= cuts_done + CUT_W'(1);
      end
    end
  end

endmodule

@@ rtl/sss_queue.sv @@
module sss_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       wr_num,
  input  sss_pkg::result_t wr_data0,
  input  sss_pkg::result_t wr_data1,
  output logic             has_room,
  sss_out_if.source        field_out
);
  import sss_pkg::*;

  result_t           entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;
  result_t           head;

  assign pop      = field_out.valid && field_out.ready;
  assign has_room = count <= QCNT_W'(QUEUE_DEPTH - 2);

  // up to two words written per cycle
  always_ff @(posedge clk) begin
    if (wr_num != 2'd0) begin
      entry[wr_ptr] <= wr_data0;
    end
    if (wr_num == 2'd2) begin
      entry[wr_ptr + QPTR_W'(1)] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(wr_num);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(wr_num) - QCNT_W'(pop);
    end
  end

  assign head                      = entry[rd_ptr];
  assign field_out.valid           = count != '0;
  assign field_out.field_start     = head.field_start;
  assign field_out.field_length    = head.field_length;
  assign field_out.final_field     = head.final_field;
  assign field_out.length_overflow = head.length_overflow;

endmodule

@@ rtl/string_split_on_separator.sv @@
// String splitter on a configured separator.
//
// str_in takes one word per string byte (byte_present) and marks the last
// word of a string with end_of_string; a word with neither flag is dropped.
// field_out gives one word per field: offset and length of the text before
// each separator match, then the final field at end of string. A word
// carrying both a byte and the end mark can give two fields.
// The separator (1 to 8 bytes), its length and the cut limit are written on
// the cfg_write/cfg_index/cfg_data port while no string is in flight.
//
// Throughput: one input word per cycle while str_in.ready is high. Matching
// runs through a row of window cells, one per separator byte, each comparing
// the byte it takes next, so a cut is known in the cycle the byte arrives. A
// field is written to the queue when the word that closes it is accepted.
// Results wait in a four-word queue; str_in.ready drops while more than two
// words are queued, so a stalled receiver stalls the sender after at most
// three more input words. Reset empties the queue, clears the string state
// and restores the registers to: separator 0, length 1, unlimited cuts.
module string_split_on_separator #(
  parameter int MAX_SEP_BYTES = 8,
  parameter int POS_WIDTH     = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sss_pkg::SEP_REG_W-1:0]    cfg_data,
  sss_in_if.sink                           str_in,
  sss_out_if.source                        field_out
);
  import sss_pkg::*;

  logic [SEP_REG_W-1:0]   sep_bytes;
  logic [LEN_REG_W-1:0]   sep_length;
  logic [SPLIT_REG_W-1:0] max_splits;
  logic [LEN_REG_W-1:0]   eff_len;

  logic                   accept;
  logic                   has_room;
  cell_ctl_t              ctl;
  result_t                res0;
  result_t                res1;
  logic [1:0]             res_num;

  logic [BYTE_W-1:0]      chain_byte  [MAX_SEP_BYTES+1];
  logic                   chain_fresh [MAX_SEP_BYTES+1];
  logic                   chain_match [MAX_SEP_BYTES+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_bytes  <= '0;
      sep_length <= LEN_REG_W'(1);
      max_splits <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEP_BYTES:  sep_bytes  <= cfg_data;
        REG_SEP_LENGTH: sep_length <= cfg_data[LEN_REG_W-1:0];
        REG_MAX_SPLITS: max_splits <= cfg_data[SPLIT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the window length
  always_comb begin
    if (sep_length == '0) begin
      eff_len = LEN_REG_W'(1);
    end else if (sep_length > LEN_REG_W'(MAX_SEP_BYTES)) begin
      eff_len = LEN_REG_W'(MAX_SEP_BYTES);
    end else begin
      eff_len = sep_length;
    end
  end

  assign str_in.ready = has_room;
  assign accept       = str_in.valid && has_room;

  // window cells, newest byte in cell 0
  assign chain_byte[0]  = str_in.data_byte;
  assign chain_fresh[0] = 1'b1;
  assign chain_match[0] = 1'b1;

  for (genvar j = 0; j < MAX_SEP_BYTES; j++) begin : g_cell
    sss_cell #(
      .INDEX         (j),
      .MAX_SEP_BYTES (MAX_SEP_BYTES)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .eff_len   (eff_len),
      .sep_bytes (sep_bytes),
      .byte_in   (chain_byte[j]),
      .fresh_in  (chain_fresh[j]),
      .match_in  (chain_match[j]),
      .byte_out  (chain_byte[j+1]),
      .fresh_out (chain_fresh[j+1]),
      .match_out (chain_match[j+1])
    );
  end

  sss_ctrl #(
    .POS_WIDTH (POS_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_present  (str_in.byte_present),
    .end_of_string (str_in.end_of_string),
    .match         (chain_match[MAX_SEP_BYTES]),
    .eff_len       (eff_len),
    .max_splits    (max_splits),
    .ctl           (ctl),
    .res0          (res0),
    .res1          (res1),
    .res_num       (res_num)
  );

  sss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_num    (res_num),
    .wr_data0  (res0),
    .wr_data1  (res1),
    .has_room  (has_room),
    .field_out (field_out)
  );

endmodule

@@ rtl/sss_checker.sv @@
module sss_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_start,
  input logic [15:0] out_length,
  input logic        out_final,
  input logic        out_overflow
);

  // a word on offer stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("field word dropped while stalled");

  // a stalled word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_start) && $stable(out_length)
      && $stable(out_final) && $stable(out_overflow))
    else $error("field word changed while stalled");

  // input back-pressure only while results are queued
  a_ready_backlog: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing to deliver");

  // reset leaves nothing queued and the input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

endmodule

bind string_split_on_separator sss_checker u_sss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (str_in.valid),
  .in_ready     (str_in.ready),
  .out_valid    (field_out.valid),
  .out_ready    (field_out.ready),
  .out_start    (field_out.field_start),
  .out_length   (field_out.field_length),
  .out_final    (field_out.final_field),
  .out_overflow (field_out.length_overflow)
);
